// ----- hw/rtl/tbc_pkg.sv -----
// Shared constants, types and the coefficient ROM for the three-axis biquad cascade.
// Depends on nothing; every other file of the block imports it.
package tbc_pkg;

   // Filter shape.
   localparam int STAGES          = 3;
   localparam int AXES            = 3;
   localparam int AXIS_FIELDS     = 3;
   localparam int ROM_STAGES      = 3;
   localparam int COEFS_PER_STAGE = 5;

   // Coefficient slots within one stage.
   localparam int SLOT_B0 = 0;
   localparam int SLOT_B1 = 1;
   localparam int SLOT_B2 = 2;
   localparam int SLOT_A1 = 3;
   localparam int SLOT_A2 = 4;

   // Number formats.
   localparam int FRAC     = 29;
   localparam int RAW_W    = 20;
   localparam int OUT_W    = 24;
   localparam int OUT_FRAC = 4;
   localparam int SIG_W    = 56;
   localparam int COEF_W   = 32;
   localparam int HALF_W   = 28;
   localparam int OPND_W   = SIG_W - HALF_W + 1;
   localparam int PROD_W   = COEF_W + OPND_W;
   localparam int ACC_W    = COEF_W + SIG_W;
   localparam int TERM_W   = ACC_W - FRAC;
   localparam int SUM_W    = TERM_W + 1;

   // Indexing.
   localparam int UNITS          = AXES * STAGES;
   localparam int DEPTH          = UNITS * 2;
   localparam int UNIT_W         = (UNITS > 1) ? $clog2(UNITS) : 1;
   localparam int ADDR_W         = UNIT_W + 1;
   localparam int AXIS_W         = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int STAGE_W        = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int NUM_COEFS      = STAGES * COEFS_PER_STAGE;
   localparam int COEF_IDX_W     = $clog2(NUM_COEFS);
   localparam int STEPS_PER_UNIT = 10;
   localparam int STEP_W         = $clog2(STEPS_PER_UNIT);

   // Operand source, operand half, sum base and result destination codes.
   localparam logic SRC_X   = 1'b0;
   localparam logic SRC_Y   = 1'b1;
   localparam logic HALF_LO = 1'b0;
   localparam logic HALF_HI = 1'b1;

   localparam logic [1:0] BASE_ACC  = 2'd0;
   localparam logic [1:0] BASE_ZERO = 2'd1;
   localparam logic [1:0] BASE_D0   = 2'd2;
   localparam logic [1:0] BASE_D1   = 2'd3;

   localparam logic [1:0] DEST_NONE = 2'd0;
   localparam logic [1:0] DEST_Y    = 2'd1;
   localparam logic [1:0] DEST_D0   = 2'd2;
   localparam logic [1:0] DEST_D1   = 2'd3;

   // One multiplier pass, carried down the arithmetic pipeline as its tag.
   typedef struct packed {
      logic                  valid;
      logic [COEF_IDX_W-1:0] coef_idx;
      logic                  src;
      logic                  half;
      logic [1:0]            base;
      logic [1:0]            dest;
      logic [UNIT_W-1:0]     unit;
   } cmd_type;

   // Per-cycle register loads outside the arithmetic pipeline.
   typedef struct packed {
      logic              req_load;
      logic              x_load;
      logic              x_from_raw;
      logic [AXIS_W-1:0] x_axis;
      logic              capture;
      logic [AXIS_W-1:0] cap_axis;
      logic              rsp_load;
   } ctl_type;

   // Coefficients as signed numerators over 10^18.
   localparam longint unsigned DEC_SCALE = 64'd1000000000000000000;

   localparam longint COEF_DEC [ROM_STAGES*COEFS_PER_STAGE] = '{
      64'sd526227224366234600, 64'sd20088014478, -64'sd526233531679917300,
      64'sd488264993257820700, 64'sd507943581150420600,
      64'sd1000000000000000000, 64'sd1999993987974677000, 64'sd999993988010820600,
      -64'sd1250534679334394000, -64'sd545880532242778200,
      64'sd1000000000000000000, -64'sd1999994026148331000, 64'sd999994026184017000,
      64'sd1997484596467384000, -64'sd997490907660220500
   };

   // Each entry holds a signed Q2.29 coefficient.
   typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_rom_type;

   // Rounds a decimal numerator to Q2.29, half away from zero.
   function automatic logic signed [COEF_W-1:0] dec_to_q29(longint num);
      logic                     neg;
      longint unsigned          mag;
      longint unsigned          q;
      longint unsigned          rem;
      logic signed [COEF_W-1:0] mag_q;
      neg = (num < 0);
      mag = neg ? longint'(-num) : longint'(num);
      q   = mag / DEC_SCALE;
      rem = mag % DEC_SCALE;
      for (int i = 0; i < FRAC; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= DEC_SCALE) begin
            q   = q | 64'd1;
            rem = rem - DEC_SCALE;
         end
      end
      if (rem * 64'd2 >= DEC_SCALE) begin
         q = q + 64'd1;
      end
      mag_q = COEF_W'(q);
      return neg ? -mag_q : mag_q;
   endfunction

   // Stages past the ROM pass the signal through unchanged.
   function automatic coef_rom_type build_coef_rom();
      coef_rom_type rom;
      for (int s = 0; s < STAGES; s++) begin
         for (int k = 0; k < COEFS_PER_STAGE; k++) begin
            if (s < ROM_STAGES) begin
               rom[s*COEFS_PER_STAGE+k] = dec_to_q29(COEF_DEC[s*COEFS_PER_STAGE+k]);
            end else if (k == SLOT_B0) begin
               rom[s*COEFS_PER_STAGE+k] = COEF_W'(1) <<< FRAC;
            end else begin
               rom[s*COEFS_PER_STAGE+k] = '0;
            end
         end
      end
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = build_coef_rom();

endpackage

// ----- hw/rtl/tbc_if.sv -----
// Valid/ready channel interfaces for the sample and result transactions.
// Depends on tbc_pkg for the payload widths.
interface tbc_req_if;
   import tbc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_x;
   logic signed [RAW_W-1:0] raw_y;
   logic signed [RAW_W-1:0] raw_z;
   modport source (output valid, raw_x, raw_y, raw_z, input ready);
   modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface tbc_rsp_if;
   import tbc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] filtered_x;
   logic signed [OUT_W-1:0] filtered_y;
   logic signed [OUT_W-1:0] filtered_z;
   modport source (output valid, filtered_x, filtered_y, filtered_z, input ready);
   modport sink (input valid, filtered_x, filtered_y, filtered_z, output ready);
endinterface

// ----- hw/rtl/tbc_ctrl.sv -----
// Controller: handshakes and the fixed schedule of multiplier passes per biquad.
// Depends on tbc_pkg for the command types and codes.
module tbc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbc_pkg::cmd_type  cmd,
   output tbc_pkg::ctl_type  ctl
);
   import tbc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Passes still in the two pipeline stages after the last issue.
   localparam int DRAIN_CYCLES = 2;

   logic [1:0]         state_ff, state_in;
   logic [AXIS_W-1:0]  axis_ff, axis_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         slot;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      stage_in = stage_ff;
      step_in  = step_ff;
      cmd      = '0;
      ctl      = '0;
      slot     = 3'(SLOT_B0);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.req_load = 1'b1;
               state_in     = ST_RUN;
               axis_in      = '0;
               stage_in     = '0;
               step_in      = '0;
            end
         end
         ST_RUN: begin
            cmd.valid = 1'b1;
            cmd.base  = BASE_ACC;
            cmd.dest  = DEST_NONE;
            cmd.unit  = UNIT_W'(int'(axis_ff) * STAGES + int'(stage_ff));
            // Two passes (low half, high half of the signal) per product.
            unique case (step_ff)
               STEP_W'(0): begin
                  slot = 3'(SLOT_B0); cmd.src = SRC_X; cmd.half = HALF_LO;
               end
               STEP_W'(1): begin
                  slot = 3'(SLOT_B0); cmd.src = SRC_X; cmd.half = HALF_HI;
                  cmd.base = BASE_D0; cmd.dest = DEST_Y;
               end
               STEP_W'(2): begin
                  slot = 3'(SLOT_B1); cmd.src = SRC_X; cmd.half = HALF_LO;
               end
               STEP_W'(3): begin
                  slot = 3'(SLOT_B1); cmd.src = SRC_X; cmd.half = HALF_HI;
                  cmd.base = BASE_D1;
               end
               STEP_W'(4): begin
                  slot = 3'(SLOT_A1); cmd.src = SRC_Y; cmd.half = HALF_LO;
               end
               STEP_W'(5): begin
                  slot = 3'(SLOT_A1); cmd.src = SRC_Y; cmd.half = HALF_HI;
                  cmd.dest = DEST_D0;
               end
               STEP_W'(6): begin
                  slot = 3'(SLOT_B2); cmd.src = SRC_X; cmd.half = HALF_LO;
               end
               STEP_W'(7): begin
                  slot = 3'(SLOT_B2); cmd.src = SRC_X; cmd.half = HALF_HI;
                  cmd.base = BASE_ZERO;
               end
               STEP_W'(8): begin
                  slot = 3'(SLOT_A2); cmd.src = SRC_Y; cmd.half = HALF_LO;
               end
               STEP_W'(9): begin
                  slot = 3'(SLOT_A2); cmd.src = SRC_Y; cmd.half = HALF_HI;
                  cmd.dest = DEST_D1;
               end
               default: begin
                  cmd.valid = 1'b0;
               end
            endcase
            cmd.coef_idx = COEF_IDX_W'(int'(stage_ff) * COEFS_PER_STAGE + int'(slot));

            if (step_ff == STEP_W'(STEPS_PER_UNIT - 1)) begin
               step_in = '0;
               if (stage_ff == STAGE_W'(STAGES - 1)) begin
                  ctl.capture  = 1'b1;
                  ctl.cap_axis = axis_ff;
                  if (axis_ff == AXIS_W'(AXES - 1)) begin
                     state_in = ST_DRAIN;
                  end else begin
                     axis_in        = AXIS_W'(axis_ff + 1'b1);
                     stage_in       = '0;
                     ctl.x_load     = 1'b1;
                     ctl.x_from_raw = 1'b1;
                     ctl.x_axis     = AXIS_W'(axis_ff + 1'b1);
                  end
               end else begin
                  stage_in   = STAGE_W'(stage_ff + 1'b1);
                  ctl.x_load = 1'b1;
               end
            end else begin
               step_in = STEP_W'(step_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (step_ff == STEP_W'(DRAIN_CYCLES - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = STEP_W'(step_ff + 1'b1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = ctl.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         stage_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         stage_ff     <= stage_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/tbc_mac.sv -----
// Shared multiplier: one coefficient times one signal half per cycle, then the
// two halves are combined and rounded into a 29-fraction-bit term. Uses tbc_pkg.
module tbc_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  tbc_pkg::cmd_type                   cmd,
   input  logic signed [tbc_pkg::SIG_W-1:0]   x_sig,
   input  logic signed [tbc_pkg::SIG_W-1:0]   y_sig,
   output tbc_pkg::cmd_type                   tag_mul,
   output tbc_pkg::cmd_type                   tag_term,
   output logic signed [tbc_pkg::TERM_W-1:0]  term
);
   import tbc_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (FRAC - 1);

   cmd_type                  tag1_ff, tag2_ff, tag2_in;
   logic signed [SIG_W-1:0]  sig;
   logic signed [OPND_W-1:0] opnd;
   logic signed [PROD_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] pr_ff, pr_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      sig = (cmd.src == SRC_Y) ? y_sig : x_sig;
      if (cmd.half == HALF_HI) begin
         opnd = {sig[SIG_W-1], sig[SIG_W-1:HALF_W]};
      end else begin
         opnd = {1'b0, sig[HALF_W-1:0]};
      end
      mul_a = PROD_W'($signed(COEF_ROM[cmd.coef_idx]));
      mul_b = PROD_W'(opnd);
      pr_in = mul_a * mul_b;
   end

   // The rounding constant rides in with the low half.
   always_comb begin
      if (tag1_ff.half == HALF_HI) begin
         acc_in = acc_ff + (ACC_W'(pr_ff) <<< HALF_W);
      end else begin
         acc_in = ACC_W'(pr_ff) + ACC_RND;
      end
      tag2_in       = tag1_ff;
      tag2_in.valid = tag1_ff.valid && (tag1_ff.half == HALF_HI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= cmd;
         tag2_ff <= tag2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         pr_ff <= pr_in;
      end
      if (tag1_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign tag_mul  = tag1_ff;
   assign tag_term = tag2_ff;
   assign term     = acc_ff[ACC_W-1:FRAC];

endmodule

// ----- hw/rtl/tbc_datapath.sv -----
// Datapath: signal registers, delay-state memory, sum and saturation, output
// rounding and the result register. Uses tbc_pkg.
module tbc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  tbc_pkg::ctl_type                   ctl,
   input  tbc_pkg::cmd_type                   tag_mul,
   input  tbc_pkg::cmd_type                   tag_term,
   input  logic signed [tbc_pkg::TERM_W-1:0]  term,
   input  logic signed [tbc_pkg::RAW_W-1:0]   raw_in [tbc_pkg::AXIS_FIELDS],
   output logic signed [tbc_pkg::SIG_W-1:0]   x_sig,
   output logic signed [tbc_pkg::SIG_W-1:0]   y_sig,
   output logic signed [tbc_pkg::OUT_W-1:0]   filtered [tbc_pkg::AXIS_FIELDS]
);
   import tbc_pkg::*;

   localparam int OUT_SHIFT = FRAC - OUT_FRAC;
   localparam int RND_W     = SIG_W + 1;
   localparam int SHIFT_W   = RND_W - OUT_SHIFT;

   localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
   localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic signed [RND_W-1:0] OUT_RND = RND_W'(1) <<< (OUT_SHIFT - 1);

   logic signed [RAW_W-1:0] raw_ff [AXES];
   logic signed [SIG_W-1:0] x_ff, x_in;
   logic signed [SIG_W-1:0] y_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SIG_W-1:0] delay_mem_ff [DEPTH];
   logic [DEPTH-1:0]        dvalid_ff;
   logic signed [SIG_W-1:0] rd_data_ff;
   logic                    rd_live_ff;
   logic signed [OUT_W-1:0] out_ff [AXES];
   logic signed [OUT_W-1:0] rsp_ff [AXES];

   logic                     rd_req;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [SUM_W-1:0]  base_val;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SIG_W-1:0]  sat_val;
   logic signed [RND_W-1:0]  rnd_sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [OUT_W-1:0]  out_val;

   function automatic logic signed [SIG_W-1:0] raw_to_sig(logic signed [RAW_W-1:0] raw);
      return SIG_W'(raw) <<< FRAC;
   endfunction

   // Delay-state reads go out in the cycle before the term that needs them.
   assign rd_req  = tag_mul.valid && (tag_mul.half == HALF_HI) &&
                    ((tag_mul.base == BASE_D0) || (tag_mul.base == BASE_D1));
   assign rd_addr = {tag_mul.unit, tag_mul.base == BASE_D1};
   assign wr_en   = tag_term.valid &&
                    ((tag_term.dest == DEST_D0) || (tag_term.dest == DEST_D1));
   assign wr_addr = {tag_term.unit, tag_term.dest == DEST_D1};

   always_comb begin
      unique case (tag_term.base)
         BASE_ACC:         base_val = sum_ff;
         BASE_ZERO:        base_val = '0;
         BASE_D0, BASE_D1: base_val = rd_live_ff ? SUM_W'(rd_data_ff) : '0;
      endcase
      sum_in = base_val + SUM_W'(term);
      if ((sum_in[SUM_W-1:SIG_W-1] == '0) || (sum_in[SUM_W-1:SIG_W-1] == '1)) begin
         sat_val = sum_in[SIG_W-1:0];
      end else begin
         sat_val = sum_in[SUM_W-1] ? SIG_MIN : SIG_MAX;
      end
   end

   always_comb begin
      rnd_sum = RND_W'(y_ff) + OUT_RND;
      shifted = rnd_sum[RND_W-1:OUT_SHIFT];
      if ((shifted[SHIFT_W-1:OUT_W-1] == '0) || (shifted[SHIFT_W-1:OUT_W-1] == '1)) begin
         out_val = shifted[OUT_W-1:0];
      end else begin
         out_val = shifted[SHIFT_W-1] ? OUT_MIN : OUT_MAX;
      end
   end

   always_comb begin
      x_in = x_ff;
      if (ctl.req_load) begin
         x_in = raw_to_sig(raw_in[0]);
      end else if (ctl.x_load) begin
         x_in = ctl.x_from_raw ? raw_to_sig(raw_ff[ctl.x_axis]) : y_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (ctl.req_load) begin
         for (int a = 0; a < AXES; a++) begin
            raw_ff[a] <= raw_in[a];
         end
      end
      if (tag_term.valid) begin
         unique case (tag_term.dest)
            DEST_NONE:        sum_ff <= sum_in;
            DEST_Y:           y_ff   <= sat_val;
            DEST_D0, DEST_D1: ;
         endcase
      end
      if (ctl.capture) begin
         out_ff[ctl.cap_axis] <= out_val;
      end
      if (ctl.rsp_load) begin
         rsp_ff <= out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req) begin
         rd_data_ff <= delay_mem_ff[rd_addr];
         rd_live_ff <= dvalid_ff[rd_addr];
      end
      if (wr_en) begin
         delay_mem_ff[wr_addr] <= sat_val;
      end
   end

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
      end else if (wr_en) begin
         dvalid_ff[wr_addr] <= 1'b1;
      end
   end

   assign x_sig = x_ff;
   assign y_sig = y_ff;

   for (genvar a = 0; a < AXIS_FIELDS; a++) begin : g_field
      if (a < AXES) begin : g_live
         assign filtered[a] = rsp_ff[a];
      end else begin : g_idle
         assign filtered[a] = '0;
      end
   end

endmodule

// ----- hw/rtl/triaxis_biquad_cascade_iir.sv -----
// Top level of the three-axis band-pass filter: a three-stage transposed
// direct form II biquad cascade per axis. Uses tbc_pkg, tbc_if, tbc_ctrl,
// tbc_mac and tbc_datapath.
//
//   Channel   Direction  Payload                               Transaction
//   req_bus   in         raw_x, raw_y, raw_z (signed 20 bits)  one sample per axis
//   rsp_bus   out        filtered_x/_y/_z (signed 24 bits)     one filtered sample per axis
//
// One 32 by 29 bit multiplier is shared by all products; each product needs two
// passes, and a biquad has five products.
// The result register lets the next sample be accepted while a result waits;
// a stalled result holds the block in its last state until it is taken.
// Reset is synchronous and active high and clears all delay states at once
// through per-entry valid bits, so no clearing pass is needed.
module triaxis_biquad_cascade_iir (
   input  logic        clock,
   input  logic        reset,
   tbc_req_if.sink     req_bus,
   tbc_rsp_if.source   rsp_bus
);
   import tbc_pkg::*;

   // The controller issues one multiplier pass per cycle while running. Each
   // pass carries a tag that tells the datapath what base the sum starts from (the
   // running sum, zero or a delay state) and where the finished, saturated sum goes.
   cmd_type                  cmd;
   ctl_type                  ctl;
   cmd_type                  tag_mul;
   cmd_type                  tag_term;
   logic signed [TERM_W-1:0] term;
   logic signed [SIG_W-1:0]  x_sig;
   logic signed [SIG_W-1:0]  y_sig;
   logic signed [RAW_W-1:0]  raw_in [AXIS_FIELDS];
   logic signed [OUT_W-1:0]  filtered [AXIS_FIELDS];
   logic                     req_ready;
   logic                     rsp_valid;

   assign raw_in[0] = req_bus.raw_x;
   assign raw_in[1] = req_bus.raw_y;
   assign raw_in[2] = req_bus.raw_z;

   tbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .ctl       (ctl)
   );

   // The multiply and the two-half combine sit in two registered stages; the
   // sum with its delay-state base is the third stage, inside the datapath.
   tbc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .x_sig    (x_sig),
      .y_sig    (y_sig),
      .tag_mul  (tag_mul),
      .tag_term (tag_term),
      .term     (term)
   );

   tbc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .tag_mul  (tag_mul),
      .tag_term (tag_term),
      .term     (term),
      .raw_in   (raw_in),
      .x_sig    (x_sig),
      .y_sig    (y_sig),
      .filtered (filtered)
   );

   assign req_bus.ready      = req_ready;
   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.filtered_x = filtered[0];
   assign rsp_bus.filtered_y = filtered[1];
   assign rsp_bus.filtered_z = filtered[2];

endmodule

// ----- sim/triaxis_biquad_cascade_iir_test.sv -----
// Self-checking testbench for the three-axis biquad cascade band-pass filter.
// Depends on tbc_pkg, the tbc_req_if and tbc_rsp_if channels and the
// triaxis_biquad_cascade_iir top level.
module triaxis_biquad_cascade_iir_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tbc_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 8;
   // Random traffic after the directed samples, and the tail of it that runs
   // with both handshakes held open.
   localparam int RANDOM_ITEMS = 1280;
   localparam int STEADY_TAIL  = 150;
   // The drain waits past the time one sample takes through every biquad on every
   // axis, to catch any stray result.
   localparam int DRAIN_CYCLES = 10 * AXES * STAGES + 4 + 32;
   // The slowest correct run is about 1300 samples, which is near 1.2 ms; the
   // watchdog allows several times that.
   localparam int TIMEOUT_NS   = 10_000_000;
   // Stages held in the coefficient table; any further stage passes through.
   localparam int ROM_DEPTH    = 3;

   typedef logic signed [127:0]     wide_type;
   typedef logic signed [SIG_W-1:0] state_type;

   localparam wide_type STATE_HI = (wide_type'(1) <<< (SIG_W - 1)) - 1;
   localparam wide_type STATE_LO = -(wide_type'(1) <<< (SIG_W - 1));
   localparam wide_type OUT_HI   = (wide_type'(1) <<< (OUT_W - 1)) - 1;
   localparam wide_type OUT_LO   = -(wide_type'(1) <<< (OUT_W - 1));

   localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W - 1){1'b1}}};
   localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W - 1){1'b0}}};

   // Band-pass design as decimal numerators over 10^18: b0, b1, b2, a1, a2 for
   // each of the three stages, feedback terms added.
   localparam longint BAND_NUMER [ROM_DEPTH*COEFS_PER_STAGE] = '{
      64'sd526227224366234600, 64'sd20088014478, -64'sd526233531679917300,
      64'sd488264993257820700, 64'sd507943581150420600,
      64'sd1000000000000000000, 64'sd1999993987974677000, 64'sd999993988010820600,
      -64'sd1250534679334394000, -64'sd545880532242778200,
      64'sd1000000000000000000, -64'sd1999994026148331000, 64'sd999994026184017000,
      64'sd1997484596467384000, -64'sd997490907660220500
   };

   typedef struct {
      logic signed [RAW_W-1:0] x;
      logic signed [RAW_W-1:0] y;
      logic signed [RAW_W-1:0] z;
   } sample_type;

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
   } filtered_type;

   // Shapes of the random sample sequences.
   typedef enum int {
      SEQ_NOISE,
      SEQ_SMALL,
      SEQ_HOLD,
      SEQ_SQUARE,
      SEQ_WALK
   } seq_kind_type;
   localparam int SEQ_KIND_COUNT = 5;

   logic clock;
   logic reset;

   tbc_req_if req_bus ();
   tbc_rsp_if rsp_bus ();

   triaxis_biquad_cascade_iir u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state: the Q2.29 coefficients and the two delay registers of
   // every biquad on every axis.
   logic signed [COEF_W-1:0] band_coef [STAGES][COEFS_PER_STAGE];
   state_type                delay_d1  [AXES][STAGES];
   state_type                delay_d2  [AXES][STAGES];

   // Filtered samples predicted at acceptance, oldest first.
   filtered_type expected_outputs [$];

   int error_count    = 0;
   bit steady_traffic = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Reference arithmetic
   // ------------------------------------------------------------------

   // Decimal numerator over 10^18 to Q2.29, rounding the magnitude half up,
   // which is half away from zero for the signed value.
   function automatic logic signed [COEF_W-1:0] to_q29(longint numer);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (numer < 0) ? 128'(-numer) : 128'(numer);
      q   = ((mag << FRAC) + 128'd500000000000000000) / 128'd1000000000000000000;
      return (numer < 0) ? -COEF_W'(q) : COEF_W'(q);
   endfunction

   // Coefficient times signal, rounded half up back to 29 fractional bits.
   function automatic wide_type scaled_product(logic signed [COEF_W-1:0] c, state_type s);
      wide_type cw;
      wide_type sw;
      cw = c;
      sw = s;
      return (cw * sw + (wide_type'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic state_type clamp_state(wide_type v);
      if (v > STATE_HI) begin
         return state_type'(STATE_HI);
      end else if (v < STATE_LO) begin
         return state_type'(STATE_LO);
      end
      return state_type'(v);
   endfunction

   // Runs one raw sample through the cascade of one axis and updates that
   // axis' delay registers.
   function automatic logic signed [OUT_W-1:0] filter_axis(int axis,
                                                          logic signed [RAW_W-1:0] raw);
      wide_type  acc;
      state_type x;
      state_type y;
      acc = raw;
      x   = state_type'(acc <<< FRAC);
      for (int s = 0; s < STAGES; s++) begin
         y = clamp_state(scaled_product(band_coef[s][SLOT_B0], x) + delay_d1[axis][s]);
         delay_d1[axis][s] = clamp_state(scaled_product(band_coef[s][SLOT_B1], x)
                                         + scaled_product(band_coef[s][SLOT_A1], y)
                                         + delay_d2[axis][s]);
         delay_d2[axis][s] = clamp_state(scaled_product(band_coef[s][SLOT_B2], x)
                                         + scaled_product(band_coef[s][SLOT_A2], y));
         x = y;
      end
      // Down to four fractional bits, half up, then clip to the output field.
      acc = x;
      acc = (acc + (wide_type'(1) <<< (FRAC - OUT_FRAC - 1))) >>> (FRAC - OUT_FRAC);
      if (acc > OUT_HI) begin
         acc = OUT_HI;
      end else if (acc < OUT_LO) begin
         acc = OUT_LO;
      end
      return OUT_W'(acc);
   endfunction

   // An axis the block does not process reports zero.
   function automatic filtered_type predict_outputs(sample_type smp);
      filtered_type out;
      out.x = '0;
      out.y = '0;
      out.z = '0;
      if (AXES > 0) begin
         out.x = filter_axis(0, smp.x);
      end
      if (AXES > 1) begin
         out.y = filter_axis(1, smp.y);
      end
      if (AXES > 2) begin
         out.z = filter_axis(2, smp.z);
      end
      return out;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers and result checker
   // ------------------------------------------------------------------

   // Drives one sample transaction. Inputs move on the falling edge; the
   // transaction completes at the first rising edge that sees ready, and
   // the prediction is made right there so the model follows the same
   // order as the block. Valid is left high afterwards, so back-to-back
   // samples never lower and raise it within one time step.
   task automatic send_sample(logic signed [RAW_W-1:0] raw_x,
                              logic signed [RAW_W-1:0] raw_y,
                              logic signed [RAW_W-1:0] raw_z);
      sample_type smp;
      smp.x = raw_x;
      smp.y = raw_y;
      smp.z = raw_z;
      @(negedge clock);
      if (!steady_traffic && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.raw_x <= smp.x;
      req_bus.raw_y <= smp.y;
      req_bus.raw_z <= smp.z;
      do @(posedge clock); while (!req_bus.ready);
      expected_outputs.push_back(predict_outputs(smp));
   endtask

   // Result side back-pressure: ready drops at random times, except in the steady
   // tail of the run.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!steady_traffic && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic compare_field(string name, logic signed [OUT_W-1:0] want,
                                logic signed [OUT_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Every result transaction is matched against the oldest prediction.
   always @(posedge clock) begin : check_outputs
      filtered_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outputs.size() == 0) begin
            error_count++;
            $display("%0t: stray result transaction, expected none, actual %0d %0d %0d",
                     $time, rsp_bus.filtered_x, rsp_bus.filtered_y, rsp_bus.filtered_z);
         end else begin
            want = expected_outputs.pop_front();
            compare_field("filtered_x", want.x, rsp_bus.filtered_x);
            compare_field("filtered_y", want.y, rsp_bus.filtered_y);
            compare_field("filtered_z", want.z, rsp_bus.filtered_z);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic signed [RAW_W-1:0] rand_raw();
      return RAW_W'($urandom);
   endfunction

   function automatic logic signed [RAW_W-1:0] small_raw();
      return RAW_W'(int'($urandom_range(0, 511)) - 256);
   endfunction

   function automatic sample_type random_sample();
      sample_type smp;
      smp.x = rand_raw();
      smp.y = rand_raw();
      smp.z = rand_raw();
      return smp;
   endfunction

   // One step of a random walk with a random step scale, kept in range.
   function automatic logic signed [RAW_W-1:0] walk_raw(logic signed [RAW_W-1:0] v);
      int n;
      n = int'(v) + ((int'($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 8));
      if (n > int'(RAW_MAX)) begin
         n = int'(RAW_MAX);
      end else if (n < int'(RAW_MIN)) begin
         n = int'(RAW_MIN);
      end
      return RAW_W'(n);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Freshly cleared delay registers must give exact zeros for zero input.
   task automatic test_quiet_input();
      send_sample('0, '0, '0);
      send_sample('0, '0, '0);
   endtask

   // Full-scale values on each field, in different axis combinations, so
   // the axes are shown to be independent.
   task automatic test_field_extremes();
      send_sample(RAW_MAX, RAW_MIN, '0);
      send_sample(RAW_MIN, '0, RAW_MAX);
      send_sample('0, RAW_MAX, RAW_MIN);
      send_sample(RAW_MAX, RAW_MAX, RAW_MAX);
      send_sample(RAW_MIN, RAW_MIN, RAW_MIN);
      send_sample(RAW_W'(-1), RAW_W'(1), RAW_W'(-1));
   endtask

   // A full-scale impulse and its decay, then a full-scale step of the opposite sign
   // that drives the slow high-pass sections hard.
   task automatic test_impulse_and_step();
      send_sample(RAW_MAX, RAW_MIN, RAW_MAX);
      repeat (3) send_sample('0, '0, '0);
      repeat (8) send_sample(RAW_MIN, RAW_MAX, RAW_MIN);
   endtask

   // Alternating full-scale swings push the output toward its clip limits.
   task automatic test_alternating_extremes();
      repeat (3) begin
         send_sample(RAW_MAX, RAW_MIN, RAW_MAX);
         send_sample(RAW_MIN, RAW_MAX, RAW_MIN);
      end
   endtask

   // Random runs of noise, small signals, held levels, square waves and
   // random walks. The last stretch runs with no idling on either side.
   task automatic test_random_traffic();
      seq_kind_type kind;
      int           sent;
      int           run_len;
      int           half_period;
      sample_type   hi;
      sample_type   lo;
      sample_type   cur;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind        = seq_kind_type'($urandom_range(0, SEQ_KIND_COUNT - 1));
         run_len     = $urandom_range(8, 40);
         half_period = $urandom_range(1, 12);
         hi          = random_sample();
         lo          = random_sample();
         cur         = hi;
         for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
            steady_traffic = (sent >= RANDOM_ITEMS - STEADY_TAIL);
            case (kind)
               SEQ_NOISE: begin
                  cur = random_sample();
               end
               SEQ_SMALL: begin
                  cur.x = small_raw();
                  cur.y = small_raw();
                  cur.z = small_raw();
               end
               SEQ_HOLD: begin
                  cur = hi;
               end
               SEQ_SQUARE: begin
                  if ((i / half_period) % 2 == 0) begin
                     cur = hi;
                  end else begin
                     cur = lo;
                  end
               end
               default: begin
                  cur.x = walk_raw(cur.x);
                  cur.y = walk_raw(cur.y);
                  cur.z = walk_raw(cur.z);
               end
            endcase
            send_sample(cur.x, cur.y, cur.z);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin : run_tests
      // Build the predictor's coefficient table; stages past the designed
      // three pass the signal through with unity b0.
      for (int s = 0; s < STAGES; s++) begin
         for (int k = 0; k < COEFS_PER_STAGE; k++) begin
            if (s < ROM_DEPTH) begin
               band_coef[s][k] = to_q29(BAND_NUMER[s*COEFS_PER_STAGE+k]);
            end else if (k == SLOT_B0) begin
               band_coef[s][k] = COEF_W'(1) <<< FRAC;
            end else begin
               band_coef[s][k] = '0;
            end
         end
      end
      for (int a = 0; a < AXES; a++) begin
         for (int s = 0; s < STAGES; s++) begin
            delay_d1[a][s] = '0;
            delay_d2[a][s] = '0;
         end
      end

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.raw_x = '0;
      req_bus.raw_y = '0;
      req_bus.raw_z = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_quiet_input();
      test_field_extremes();
      test_impulse_and_step();
      test_alternating_extremes();
      test_random_traffic();

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain: every sample yields one result, so wait for the store to
      // empty, then a bit more to catch anything extra.
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
